/* rtl/angle_bias_kalman_filter_core_defines.svh */
// Assertion macros for the angle/bias filter core
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
// Assert an implication on aclk, disabled while aresetn is low
`define ABK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Assert a next-cycle implication on aclk, disabled while aresetn is low
`define ABK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/abk_pkg.sv */
// Package of the angle/bias filter core: types, constants and helpers
`default_nettype none
package abk_pkg;
    localparam int COV_FRAC_BITS_DEF = 24;
    localparam int DT_FRAC_BITS = 16;
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
    localparam logic [30:0] BIAS_NOISE_RST = 31'd50332;
    localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
        ST_DIV0, ST_DIVW0, ST_DIV1, ST_DIVW1,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -66'sh80000000) return -32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

/* rtl/abk_div.sv */
// Restoring divider: signed 64/64 quotient truncated toward zero, one bit a cycle
`default_nettype none
module abk_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire abk_pkg::div_req_t  req,
    output logic                    done,
    output logic signed [63:0]      quot
);
    logic [63:0] rem_reg, rem_next, dvs_reg, dvs_next, q_reg, q_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;

    always_comb begin
        rem_next = rem_reg; dvs_next = dvs_reg; q_next = q_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; neg_next = neg_reg;
        done_next = 1'b0;
        shifted = {rem_reg[62:0], q_reg[63]};
        trial = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start) begin
            q_next = req.num[63] ? 64'(-req.num) : req.num;
            dvs_next = req.den[63] ? 64'(-req.den) : req.den;
            neg_next = req.num[63] ^ req.den[63];
            rem_next = '0; cnt_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next; dvs_reg <= dvs_next; q_reg <= q_next; neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule
`default_nettype wire

/* rtl/abk_mul.sv */
// Shared registered multiplier: signed 33x34 product with a floor shift
`default_nettype none
module abk_mul (
    input  wire logic               aclk,
    input  wire logic signed [32:0] op_a,
    input  wire logic signed [33:0] op_b,
    input  wire logic               frac_sel,
    output logic signed [65:0]      prod_sh
);
    parameter int COV_FRAC_BITS = abk_pkg::COV_FRAC_BITS_DEF;
    logic signed [65:0] prod_reg, prod_next;
    logic frac_reg;

    always_comb begin
        prod_next = 66'(op_a) * 66'(op_b);
    end
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        frac_reg <= frac_sel;
    end
    // arithmetic shift is floor
    assign prod_sh = frac_reg ? (prod_reg >>> COV_FRAC_BITS)
                              : (prod_reg >>> abk_pkg::DT_FRAC_BITS);
endmodule
`default_nettype wire

/* rtl/angle_bias_kalman_filter_core.sv */
// Top level of the two-state angle/bias filter core
// Usage:
//  - Input channel s_valid/s_ready carries measured_angle, rate (Q16.16)
//    and step_time (Q0.16). Result channel m_valid/m_ready returns the
//    filtered angle and rate bias (Q16.16), one result per request.
//  - Config channel cfg_valid/cfg_ready with cfg_index/cfg_data writes the
//    three noise registers (0 angle, 1 bias, 2 measurement); cfg_ready is
//    high only while idle. Unknown indexes are dropped.
//  - After acceptance the core runs the predict steps, then two gain
//    divisions (issue, bit steps of the shared divider, pick-up) and the
//    correction steps on one shared multiplier, then raises m_valid.
//    A zero divisor skips both divisions.
//  - s_ready is low from acceptance until the result is taken, so the core
//    does not accept a new request until it is through with the last one.
//  - Reset clears the estimates and covariance and restores noise defaults.
//  - A stalled receiver holds the result in the output register; the core
//    waits until it is taken.
`default_nettype none
`include "angle_bias_kalman_filter_core_defines.svh"
module angle_bias_kalman_filter_core #(
    parameter int COV_FRAC_BITS = abk_pkg::COV_FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_measured_angle,
    input  wire logic signed [31:0] s_rate,
    input  wire logic [15:0]        s_step_time,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_filtered_angle,
    output logic signed [31:0]      m_rate_bias,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data
);
    abk_pkg::state_t state_reg, state_next;
    logic [30:0] an_reg, bn_reg, mn_reg;
    logic signed [31:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [31:0] paa_reg, paa_next, pab_reg, pab_next;
    logic signed [31:0] pba_reg, pba_next, pbb_reg, pbb_next;
    logic signed [31:0] meas_reg, rate_reg, k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0] y_reg, y_next, dpbb_reg, dpbb_next;
    logic [15:0] dt_reg;
    logic signed [32:0] op_a;
    logic signed [33:0] op_b;
    logic frac_sel;
    logic signed [65:0] prod_sh;
    abk_pkg::div_req_t dreq;
    logic div_done;
    logic signed [63:0] quot;
    logic signed [33:0] s_sum;
    logic signed [63:0] one_scale;
    logic signed [33:0] term;
    logic pend_paa_reg;
    logic m_stall;

    // Load noise writes into the noise registers while idle
    assign cfg_ready = (state_reg == abk_pkg::ST_IDLE);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            an_reg <= abk_pkg::ANGLE_NOISE_RST;
            bn_reg <= abk_pkg::BIAS_NOISE_RST;
            mn_reg <= abk_pkg::MEASURE_NOISE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                abk_pkg::REG_ANGLE_NOISE:   an_reg <= cfg_data;
                abk_pkg::REG_BIAS_NOISE:    bn_reg <= cfg_data;
                abk_pkg::REG_MEASURE_NOISE: mn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    abk_mul #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
        .aclk(aclk), .op_a(op_a), .op_b(op_b), .frac_sel(frac_sel), .prod_sh(prod_sh)
    );
    abk_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(div_done), .quot(quot));

    assign s_sum = 34'(paa_reg) + 34'($signed({1'b0, mn_reg}));
    assign one_scale = 64'sd1 <<< COV_FRAC_BITS;
    // Angle covariance term from the covariance before the cross-term update
    assign term = 34'(dpbb_reg) - 34'(pab_reg) - 34'(pba_reg)
                + 34'($signed({1'b0, an_reg}));
    assign s_ready = (state_reg == abk_pkg::ST_IDLE);
    assign m_valid = (state_reg == abk_pkg::ST_OUT);
    assign m_stall = m_valid && !m_ready;
    assign m_filtered_angle = ang_reg;
    assign m_rate_bias = bias_reg;

    // Sequencer: a multiply step issues a product and the step after it consumes that product
    always_comb begin
        state_next = state_reg;
        ang_next = ang_reg; bias_next = bias_reg;
        paa_next = paa_reg; pab_next = pab_reg; pba_next = pba_reg; pbb_next = pbb_reg;
        k0_next = k0_reg; k1_next = k1_reg; y_next = y_reg; dpbb_next = dpbb_reg;
        op_a = '0; op_b = '0; frac_sel = 1'b0;
        dreq.start = 1'b0; dreq.num = '0; dreq.den = '0;
        case (state_reg)
            abk_pkg::ST_IDLE: if (s_valid) state_next = abk_pkg::ST_P1;
            abk_pkg::ST_P1: begin
                op_a = 33'($signed({1'b0, dt_reg}));
                op_b = 34'(rate_reg) - 34'(bias_reg);
                state_next = abk_pkg::ST_P2;
            end
            abk_pkg::ST_P2: begin
                ang_next = abk_pkg::sat32(66'(ang_reg) + prod_sh);
                op_a = 33'($signed({1'b0, dt_reg}));
                op_b = 34'(pbb_reg);
                state_next = abk_pkg::ST_P3;
            end
            abk_pkg::ST_P3: begin
                // dt*pbb fits 32 bits since dt < 1
                dpbb_next = prod_sh[31:0];
                op_a = 33'($signed({1'b0, dt_reg}));
                op_b = 34'($signed({1'b0, bn_reg[30:0]}));
                state_next = abk_pkg::ST_P4;
            end
            abk_pkg::ST_P4: begin
                pbb_next = abk_pkg::sat32(66'(pbb_reg) + prod_sh);
                pab_next = abk_pkg::sat32(66'(pab_reg) - 66'(dpbb_reg));
                pba_next = abk_pkg::sat32(66'(pba_reg) - 66'(dpbb_reg));
                // issue dt * term while pab/pba still hold the old values
                op_a = 33'($signed({1'b0, dt_reg}));
                op_b = term;
                state_next = abk_pkg::ST_P5;
            end
            abk_pkg::ST_P5: begin
                paa_next = abk_pkg::sat32(66'(paa_reg) + prod_sh);
                state_next = abk_pkg::ST_P6;
            end
            abk_pkg::ST_P6: state_next = abk_pkg::ST_P7;
            abk_pkg::ST_P7: state_next = abk_pkg::ST_DIV0;
            abk_pkg::ST_DIV0: begin
                if (s_sum == '0) begin
                    k0_next = '0; k1_next = '0;
                    state_next = abk_pkg::ST_C1;
                end else begin
                    dreq.start = 1'b1;
                    dreq.num = 64'(paa_reg) * one_scale;
                    dreq.den = 64'(s_sum);
                    state_next = abk_pkg::ST_DIVW0;
                end
            end
            abk_pkg::ST_DIVW0: if (div_done) begin
                k0_next = abk_pkg::sat32(66'(quot));
                state_next = abk_pkg::ST_DIV1;
            end
            abk_pkg::ST_DIV1: begin
                dreq.start = 1'b1;
                dreq.num = 64'(pba_reg) * one_scale;
                dreq.den = 64'(s_sum);
                state_next = abk_pkg::ST_DIVW1;
            end
            abk_pkg::ST_DIVW1: if (div_done) begin
                k1_next = abk_pkg::sat32(66'(quot));
                state_next = abk_pkg::ST_C1;
            end
            abk_pkg::ST_C1: begin
                y_next = abk_pkg::sat32(66'(meas_reg) - 66'(ang_reg));
                state_next = abk_pkg::ST_C2;
            end
            abk_pkg::ST_C2: begin
                op_a = 33'(k0_reg); op_b = 34'(y_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_C3;
            end
            abk_pkg::ST_C3: begin
                ang_next = abk_pkg::sat32(66'(ang_reg) + prod_sh);
                op_a = 33'(k1_reg); op_b = 34'(y_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_C4;
            end
            abk_pkg::ST_C4: begin
                bias_next = abk_pkg::sat32(66'(bias_reg) + prod_sh);
                op_a = 33'(k1_reg); op_b = 34'(pab_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_C5;
            end
            abk_pkg::ST_C5: begin
                pbb_next = abk_pkg::sat32(66'(pbb_reg) - prod_sh);
                op_a = 33'(k1_reg); op_b = 34'(paa_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_C6;
            end
            abk_pkg::ST_C6: begin
                pba_next = abk_pkg::sat32(66'(pba_reg) - prod_sh);
                op_a = 33'(k0_reg); op_b = 34'(pab_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_C7;
            end
            abk_pkg::ST_C7: begin
                pab_next = abk_pkg::sat32(66'(pab_reg) - prod_sh);
                op_a = 33'(k0_reg); op_b = 34'(paa_reg); frac_sel = 1'b1;
                state_next = abk_pkg::ST_OUT;
            end
            abk_pkg::ST_OUT: begin
                if (m_ready) state_next = abk_pkg::ST_IDLE;
            end
            default: state_next = abk_pkg::ST_IDLE;
        endcase
        // final paa update consumes the C7 product in OUT's first cycle
        if (state_reg == abk_pkg::ST_C7) frac_sel = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abk_pkg::ST_IDLE;
            ang_reg <= '0; bias_reg <= '0;
            paa_reg <= '0; pab_reg <= '0; pba_reg <= '0; pbb_reg <= '0;
            pend_paa_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ang_reg <= ang_next; bias_reg <= bias_next;
            pab_reg <= pab_next; pba_reg <= pba_next; pbb_reg <= pbb_next;
            pend_paa_reg <= (state_reg == abk_pkg::ST_C7);
            if (pend_paa_reg) paa_reg <= abk_pkg::sat32(66'(paa_reg) - prod_sh);
            else paa_reg <= paa_next;
        end
        k0_reg <= k0_next; k1_reg <= k1_next; y_reg <= y_next; dpbb_reg <= dpbb_next;
        if (s_valid && s_ready) begin
            meas_reg <= s_measured_angle;
            rate_reg <= s_rate;
            dt_reg <= s_step_time;
        end
    end

    `ABK_ASSERT_IMP(a_ready_idle, s_valid && s_ready, !m_valid, "accept while result pending")
    `ABK_ASSERT_NXT(a_accept_busy, s_valid && s_ready, !s_ready, "ready after accept")
    `ABK_ASSERT_NXT(a_out_hold, m_stall, m_valid && $stable(m_filtered_angle), "result dropped")
endmodule
`default_nettype wire
